>>> src/lkv_pkg.sv
package lkv_pkg;

	// Request codes carried on req_type.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// Width and reset value of the capacity register.
	localparam int unsigned CFG_W = 5;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		ST_IDLE,
		ST_ACT
	} st_t;

	// Per-cell command for one cycle. Shift takes the neighbor above,
	// load takes the broadcast entry; shift wins nothing, they never meet.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

>>> src/lkv_cell.sv
module lkv_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  lkv_pkg::cell_ctl_t    ctl,
	input  logic [KEY_BITS-1:0]   up_key,
	input  logic [VALUE_BITS-1:0] up_value,
	input  logic [KEY_BITS-1:0]   load_key,
	input  logic [VALUE_BITS-1:0] load_value,
	input  logic [KEY_BITS-1:0]   cmp_key,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] value,
	output logic                  match
);
	import lkv_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// Unless it holds, the entry either moves one place toward the least recent end or is
	// replaced by the entry that becomes most recent.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= load_key;
			value_q <= load_value;
		end else if (ctl.shift) begin
			key_q   <= up_key;
			value_q <= up_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = (key_q == cmp_key);

endmodule

>>> src/lru_key_value_cache.sv
// Channel  | Direction | Handshake            | Payload
// request  | in        | in_valid / in_stall  | req_type, key_in, value_in
// result   | out       | out_valid / out_stall| success, read_value
// config   | in        | cfg_wr_en            | cfg_wr_data (capacity_in_use)
//
// Each request has a lookup cycle at the transfer edge, when every cell compares
// its key with key_in at once, and an update cycle, when cells of the row shift by
// one place or take the entry that becomes most recent.
// Reset clears the fill count, the control state and the result valid flag; the
// cell contents need no reset, since only cells below the fill count are used.
// A stalled result holds the update cycle until the result register drains.
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [KEY_BITS-1:0]           key_in,
	input  logic [VALUE_BITS-1:0]         value_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          success,
	output logic [VALUE_BITS-1:0]         read_value,
	input  logic                          cfg_wr_en,
	input  logic [lkv_pkg::CFG_W-1:0]     cfg_wr_data
);
	import lkv_pkg::*;

	// The fill count has to hold ENTRIES itself.
	localparam int FW = $clog2(ENTRIES + 1);

	// Cells are kept in recency order: cell 0 holds the least recently used
	// entry and cell fill_q-1 the most recent one. Cells at or above the fill
	// count hold nothing of meaning.

	st_t state_q, state_d;

	logic [CFG_W-1:0]      cap_q;
	logic [FW-1:0]         cap_eff;
	logic [FW-1:0]         fill_q;
	logic [1:0]            req_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  found_q;
	logic [FW-1:0]         pos_q;
	logic [VALUE_BITS-1:0] rd_q;

	logic                  out_valid_q;
	logic                  success_q;
	logic [VALUE_BITS-1:0] read_value_q;

	logic                  in_xfer;
	logic                  act_go;
	logic                  look_ev;
	logic [FW-1:0]         top;

	logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
	logic [VALUE_BITS-1:0] cell_value [ENTRIES];
	logic [ENTRIES-1:0]    cell_match;
	logic [ENTRIES-1:0]    hit;
	cell_ctl_t             cell_ctl   [ENTRIES];

	logic [FW-1:0]         hit_idx;
	logic [VALUE_BITS-1:0] hit_value;
	logic                  found_c;
	logic [FW-1:0]         pos_c;
	logic [VALUE_BITS-1:0] load_value;

	// A capacity of zero behaves as one, and one above ENTRIES as ENTRIES.
	always_comb begin
		if (int'(cap_q) > ENTRIES) begin
			cap_eff = FW'(ENTRIES);
		end else if (cap_q == '0) begin
			cap_eff = FW'(1);
		end else begin
			cap_eff = FW'(cap_q);
		end
	end

	assign in_xfer = in_valid && !in_stall;

	// An insert into a full cache drops the least recent entry in the lookup
	// cycle by shifting the whole row down one place.
	assign look_ev = in_xfer && (req_type == REQ_INSERT) && (fill_q >= cap_eff);
	assign top     = fill_q - FW'(1);

	// Insert refreshes with the new value, get moves the stored value up.
	assign load_value = (req_q == REQ_INSERT) ? value_q : rd_q;

	// State machine: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				if (!(out_valid_q && out_stall)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State machine: outputs.
	always_comb begin
		in_stall = 1'b1;
		act_go   = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_ACT:  act_go   = !(out_valid_q && out_stall);
			default: in_stall = 1'b1;
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			localparam logic [FW-1:0] IDX = FW'(g);
			logic [KEY_BITS-1:0]   up_key;
			logic [VALUE_BITS-1:0] up_value;

			if (g == ENTRIES - 1) begin : g_top
				assign up_key   = cell_key[g];
				assign up_value = cell_value[g];
			end else begin : g_mid
				assign up_key   = cell_key[g+1];
				assign up_value = cell_value[g+1];
			end

			assign hit[g] = cell_match[g] && (IDX < fill_q);

			always_comb begin
				cell_ctl[g] = '0;
				if (look_ev) begin
					cell_ctl[g].shift = 1'b1;
				end else if (act_go) begin
					case (req_q)
						REQ_INSERT: begin
							if (found_q) begin
								cell_ctl[g].load  = (IDX == top);
								cell_ctl[g].shift = (IDX >= pos_q) && (IDX < top);
							end else begin
								cell_ctl[g].load  = (IDX == fill_q);
							end
						end
						REQ_GET: begin
							if (found_q) begin
								cell_ctl[g].load  = (IDX == top);
								cell_ctl[g].shift = (IDX >= pos_q) && (IDX < top);
							end
						end
						REQ_REMOVE: begin
							if (found_q) begin
								cell_ctl[g].shift = (IDX >= pos_q);
							end
						end
						default: cell_ctl[g] = '0;
					endcase
				end
			end

			lkv_cell #(
				.KEY_BITS  (KEY_BITS),
				.VALUE_BITS(VALUE_BITS)
			) u_cell (
				.clk       (clk),
				.ctl       (cell_ctl[g]),
				.up_key    (up_key),
				.up_value  (up_value),
				.load_key  (key_q),
				.load_value(load_value),
				.cmp_key   (key_in),
				.key       (cell_key[g]),
				.value     (cell_value[g]),
				.match     (cell_match[g])
			);
		end
	endgenerate

	// Keys are unique in the row, so at most one cell hits and an OR over
	// the cells gives its place and its value.
	always_comb begin
		hit_idx   = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit[i]) begin
				hit_idx   = hit_idx | FW'(i);
				hit_value = hit_value | cell_value[i];
			end
		end
	end

	// A hit on the entry being evicted counts as a miss, and every other hit
	// moves down one place with the eviction shift.
	assign found_c = (|hit) && !(look_ev && hit[0]);
	assign pos_c   = look_ev ? (hit_idx - FW'(1)) : hit_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (look_ev) begin
				fill_q <= fill_q - FW'(1);
			end else if (act_go) begin
				if (req_q == REQ_INSERT && !found_q) begin
					fill_q <= fill_q + FW'(1);
				end else if (req_q == REQ_REMOVE && found_q) begin
					fill_q <= fill_q - FW'(1);
				end
			end
			if (act_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q   <= req_type;
			key_q   <= key_in;
			value_q <= value_in;
			found_q <= found_c;
			pos_q   <= pos_c;
			rd_q    <= hit_value;
		end
		if (act_go) begin
			success_q    <= (req_q == REQ_INSERT) ||
				((req_q == REQ_GET || req_q == REQ_REMOVE) && found_q);
			read_value_q <= (req_q == REQ_GET && found_q) ? rd_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign read_value = read_value_q;

	// The row never holds more entries than it has cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(ENTRIES))
		else $error("fill count above the number of cells");

	// Every transfer is followed by its update cycle.
	a_xfer_act: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_ACT)
		else $error("transfer not followed by the update cycle");

	// A result appears only out of an update cycle.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ACT))
		else $error("result without an update cycle");

	// An insert always completes.
	a_ins_ok: assert property (@(posedge clk) disable iff (!arst_n)
		act_go && req_q == REQ_INSERT |=> success_q)
		else $error("insert reported as failed");

	// An eviction takes exactly one entry out of the row.
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		look_ev |=> fill_q == $past(fill_q) - FW'(1))
		else $error("eviction did not lower the fill count by one");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the LRU key-value cache.
//
// Requests go in through a valid/stall channel, one transfer per request, and
// every request gives exactly one result transfer. At the moment a request
// transfer is seen, a behavioral copy of the cache state is updated and the
// outcome it gives is queued. The result monitor takes the oldest queued
// outcome for each result transfer and compares success and read_value.
module tb_top;
	import lkv_pkg::*;

	localparam int ENTRIES = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 6;
	localparam int POOL_SIZE = 20;
	localparam int PHASE_ITEMS = 215;

	// Code 3 on req_type is not a request; the cache must answer it with a
	// failed result and leave its state alone.
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct {
		logic        success;
		logic [31:0] read_value;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [31:0] key_in;
	logic [31:0] value_in;
	logic        out_valid;
	logic        out_stall;
	logic        success;
	logic [31:0] read_value;
	logic        cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	lru_key_value_cache #(
		.ENTRIES(ENTRIES),
		.KEY_BITS(32),
		.VALUE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.key_in(key_in),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.success(success),
		.read_value(read_value),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Shadow copy of the cache. Rank 0 is the least recently used live slot,
	// and the most recent live slot holds rank shadow_fill-1.
	logic [31:0]      shadow_key [ENTRIES];
	logic [31:0]      shadow_val [ENTRIES];
	bit               shadow_live[ENTRIES];
	int unsigned      shadow_rank[ENTRIES];
	int unsigned      shadow_fill;
	logic [CFG_W-1:0] shadow_cap;

	// Outcomes of accepted requests whose result transfer is still due.
	outcome_t awaited[$];

	// Percent chance per cycle that the sender holds off or the receiver stalls.
	int send_idle_pct = 37;
	int stall_pct = 55;

	int n_fail = 0;
	int n_insert = 0;
	int n_get = 0;
	int n_remove = 0;
	int n_unknown = 0;
	int n_hits = 0;
	int n_evictions = 0;
	int n_cap_writes = 0;
	int n_results = 0;
	int quiet_cycles = 0;

	logic [31:0] key_pool[POOL_SIZE];

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver stalls at random, and not at all in the last set of phases.
	initial out_stall = 1'b0;
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: a run in which no transfer happens on either channel for this
	// many cycles is hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, awaited.size());
			$display("lru_key_value_cache: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Shadow model of the cache
	// ---------------------------------------------------------------------

	function automatic int slot_of(logic [31:0] key);
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_live[i] && shadow_key[i] == key)
				return i;
		return -1;
	endfunction

	// Every live slot ranked above r moves one step toward least recent.
	function automatic void close_gap(int unsigned r);
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_live[i] && shadow_rank[i] > r)
				shadow_rank[i]--;
	endfunction

	function automatic void drop_slot(int s);
		int unsigned r;
		r = shadow_rank[s];
		shadow_live[s] = 1'b0;
		shadow_rank[s] = 0;
		close_gap(r);
		if (shadow_fill > 0)
			shadow_fill--;
	endfunction

	function automatic void touch_slot(int s);
		close_gap(shadow_rank[s]);
		shadow_rank[s] = (shadow_fill > 0) ? shadow_fill - 1 : 0;
	endfunction

	function automatic void evict_oldest();
		for (int i = 0; i < ENTRIES; i++) begin
			if (shadow_live[i] && shadow_rank[i] == 0) begin
				drop_slot(i);
				n_evictions++;
				return;
			end
		end
	endfunction

	// Applies one request to the shadow cache and returns the result it gives.
	function automatic outcome_t apply_request(logic [1:0] kind, logic [31:0] key,
			logic [31:0] value);
		outcome_t    res;
		int          s;
		int unsigned cap;
		res.success = 1'b0;
		res.read_value = '0;
		// A capacity of zero behaves as one, anything above the slot count as full size.
		cap = 32'(shadow_cap);
		if (cap < 1)
			cap = 1;
		if (cap > ENTRIES)
			cap = ENTRIES;
		case (kind)
			REQ_INSERT: begin
				n_insert++;
				// A full cache drops its oldest entry first, even when the key
				// is already present; that key may then come back as a new entry.
				if (shadow_fill >= cap)
					evict_oldest();
				s = slot_of(key);
				if (s >= 0) begin
					shadow_val[s] = value;
					touch_slot(s);
					res.success = 1'b1;
				end else begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (!shadow_live[i]) begin
							shadow_key[i] = key;
							shadow_val[i] = value;
							shadow_live[i] = 1'b1;
							shadow_rank[i] = shadow_fill;
							shadow_fill++;
							res.success = 1'b1;
							break;
						end
					end
				end
			end
			REQ_GET: begin
				n_get++;
				s = slot_of(key);
				if (s >= 0) begin
					res.read_value = shadow_val[s];
					touch_slot(s);
					res.success = 1'b1;
					n_hits++;
				end
			end
			REQ_REMOVE: begin
				n_remove++;
				s = slot_of(key);
				if (s >= 0) begin
					drop_slot(s);
					res.success = 1'b1;
				end
			end
			default: begin
				n_unknown++;
			end
		endcase
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Result monitor
	// ---------------------------------------------------------------------

	// Outputs are sampled right after the edge, before any register of the
	// cache or of this bench takes its new value, so they read as they stood
	// at the edge itself.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (awaited.size() == 0) begin
				$error("result transfer with no request outstanding");
				n_fail++;
			end else begin
				want = awaited[0];
				awaited.delete(0);
				if (success !== want.success) begin
					$error("success: expected %0d, actual %0d", want.success, success);
					n_fail++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %08h, actual %08h",
						want.read_value, read_value);
					n_fail++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Shared tasks
	// ---------------------------------------------------------------------

	// Drives one request, holding it until the cache takes it, and queues the
	// result the shadow model predicts. Random hold-off cycles come first.
	task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
			input logic [31:0] value);
		outcome_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		key_in <= key;
		value_in <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = apply_request(kind, key, value);
		awaited.insert(awaited.size(), res);
	endtask

	// Lowers valid and waits until every queued result has come back. The
	// first wait always reaches a clock edge, so valid is never lowered and raised
	// again within one time step.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited.size() != 0);
	endtask

	// The capacity register is written only with the cache idle: nothing
	// outstanding, then a settling wait for the last update to finish.
	task automatic set_capacity(input logic [CFG_W-1:0] cap);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		shadow_cap = cap;
		n_cap_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset capacity: hits, misses, updates, removes and the unknown code,
	// with the all-zero and all-one key and value.
	task automatic test_basic_requests();
		send_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(REQ_GET, 32'h1234_5678, 32'h0);
		send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_REMOVE, 32'h0000_0000, 32'h0);
		send_request(REQ_REMOVE, 32'h0000_0000, 32'h0);
		send_request(REQ_GET, 32'h0000_0000, 32'h0);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
		send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0);
	endtask

	// Capacity of one: an insert of a key that is already there evicts it and
	// then appends it again. Capacity of zero must act as one.
	task automatic test_capacity_extremes();
		set_capacity(5'd1);
		send_request(REQ_INSERT, 32'hA5A5_0001, 32'h0000_0011);
		send_request(REQ_INSERT, 32'hA5A5_0001, 32'h0000_0022);
		send_request(REQ_GET, 32'hA5A5_0001, 32'h0);
		send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0);
		set_capacity(5'd0);
		send_request(REQ_INSERT, 32'h5A5A_0002, 32'h0000_0033);
		send_request(REQ_GET, 32'hA5A5_0001, 32'h0);
	endtask

	// A capacity above the slot count acts as full size; lowering the capacity
	// under the fill makes each insert evict just one oldest entry.
	task automatic test_capacity_shrink();
		set_capacity(5'd31);
		send_request(REQ_INSERT, 32'h0000_1001, 32'h0000_0101);
		send_request(REQ_INSERT, 32'h0000_1002, 32'h0000_0102);
		send_request(REQ_INSERT, 32'h0000_1003, 32'h0000_0103);
		set_capacity(5'd2);
		send_request(REQ_INSERT, 32'h0000_1004, 32'h0000_0104);
		send_request(REQ_GET, 32'h5A5A_0002, 32'h0);
		send_request(REQ_GET, 32'h0000_1001, 32'h0);
	endtask

	// Random traffic over a small pool of keys, so that hits, updates,
	// evictions and removes of live keys are common. A few keys are drawn
	// fresh, and now and then the sender waits for the cache to go quiet.
	task automatic test_random_traffic(input int items, input logic [CFG_W-1:0] cap);
		int          pick;
		logic [1:0]  kind;
		logic [31:0] key;
		set_capacity(cap);
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				kind = REQ_INSERT;
			else if (pick < 78)
				kind = REQ_GET;
			else if (pick < 96)
				kind = REQ_REMOVE;
			else
				kind = REQ_UNKNOWN;
			if ($urandom_range(9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			if ($urandom_range(99) == 0)
				drain_results();
			send_request(kind, key, $urandom);
		end
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin
		logic [CFG_W-1:0] cap_plan[9];
		cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd2, 5'd12, 5'd7, 5'd8};
		cap_plan[7] = CFG_W'($urandom_range(31));

		for (int i = 0; i < ENTRIES; i++) begin
			shadow_live[i] = 1'b0;
			shadow_rank[i] = 0;
		end
		shadow_fill = 0;
		shadow_cap = CAP_RESET;

		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_INSERT;
		key_in = '0;
		value_in = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_requests();
		test_capacity_extremes();
		test_capacity_shrink();

		// Three phases with a busy sender and a stalling receiver, three the
		// other way round, and three with no idling on either side.
		for (int p = 0; p < 9; p++) begin
			case (p / 3)
				0: begin
					send_idle_pct = 37;
					stall_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					stall_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			test_random_traffic(PHASE_ITEMS, cap_plan[p]);
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d requests: %0d inserts, %0d gets (%0d hits), %0d removes, %0d unknown.",
			n_insert + n_get + n_remove + n_unknown, n_insert, n_get, n_hits, n_remove,
			n_unknown);
		$display("Checked %0d results across %0d capacity writes; %0d oldest-entry evictions.",
			n_results, n_cap_writes, n_evictions);
		if (n_fail == 0)
			$display("lru_key_value_cache: match");
		else
			$display("lru_key_value_cache: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
src/lkv_pkg.sv
src/lkv_cell.sv
src/lru_key_value_cache.sv
verif/tb_top.sv
